[hdl/hip_pkg.sv]
// shared constants, coefficient table and types for the heat index polynomial pipeline
package hip_pkg;

   // fixed-point formats
   localparam int FRAC_BITS = 8;                     // fraction bits of samples and result
   localparam int CFRAC     = 44;                    // fraction bits of the coefficients
   localparam int T_W       = 17;                    // temperature width, signed
   localparam int RH_W      = 15;                    // humidity width, unsigned
   localparam int OUT_W     = 24;                    // heat index width, signed
   localparam int X_W       = 17;                    // multiplier operand width, signed

   // accumulator and Horner product split
   localparam int ACC_W     = 64;
   localparam int MAG_W     = ACC_W - 1;             // magnitude of the accumulator
   localparam int LO_W      = 32;
   localparam int HI_W      = MAG_W - LO_W;
   localparam int PL_W      = LO_W + X_W;
   localparam int PH_W      = HI_W + X_W;
   localparam int SH_P      = LO_W - FRAC_BITS;      // left shift of the high partial product
   localparam int CAP_B     = MAG_W - 1 - SH_P;      // high partial bits at or above this cap
   localparam int LS_W      = PL_W + 1;              // low partial plus rounding half

   // final conversion
   localparam int ROUND_SH  = CFRAC - FRAC_BITS;
   localparam int RM_W      = MAG_W - ROUND_SH;
   localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;
   localparam int OUT_MIN_M = 1 << (OUT_W - 1);      // magnitude of the most negative result

   typedef logic signed [ACC_W-1:0] acc_type;

   // enables of the two register stages of one Horner step
   typedef struct packed {
      logic p;
      logic s;
   } step_en_type;

   // coefficient of t^i * rh^j at [i][j], Q44
   localparam acc_type COEF [4][4] = '{
      '{ 64'sd297712564429652, 64'sd94635581529192, 64'sd128229092234, 64'sd512958238 },
      '{ 64'sd3258283961658, -64'sd1763687019697, -64'sd14337121453, 64'sd3474158 },
      '{ 64'sd165664736371, 64'sd6075848479, 64'sd179619738, 64'sd14835 },
      '{ -64'sd679867622, 64'sd25107744, -64'sd384264, -64'sd848 }
   };

endpackage

[hdl/hip_step.sv]
// one Horner step y = c + round(a * x / 2^FRAC_BITS), two register stages
module hip_step import hip_pkg::*; (
   input  logic               clock,
   input  step_en_type        en,
   input  acc_type            a,
   input  acc_type            c,
   input  logic signed [X_W-1:0] x,
   output acc_type            y
);

   logic [ACC_W-1:0] a_abs;
   logic [MAG_W-1:0] a_mag;
   logic [X_W-1:0]   x_mag;
   logic [PL_W-1:0]  p_lo_in, p_lo_ff;
   logic [PH_W-1:0]  p_hi_in, p_hi_ff;
   logic             neg_in, neg_ff;
   acc_type          c_ff;

   logic             cap;
   logic [LS_W-1:0]  lo_sum;
   logic [MAG_W-1:0] q_sum, q_cap;
   acc_type          prod;
   acc_type          y_in, y_ff;

   localparam logic [MAG_W-1:0] CAP_VAL = MAG_W'(1) << (MAG_W - 1);
   localparam logic [LS_W-1:0]  HALF    = LS_W'(1) << (FRAC_BITS - 1);

   // partial products on magnitudes
   always_comb begin
      a_abs   = a[ACC_W-1] ? -a : a;
      a_mag   = a_abs[MAG_W-1:0];
      x_mag   = x[X_W-1] ? X_W'(-x) : X_W'(x);
      neg_in  = a[ACC_W-1] ^ x[X_W-1];
      p_lo_in = PL_W'(a_mag[LO_W-1:0]) * PL_W'(x_mag);
      p_hi_in = PH_W'(a_mag[MAG_W-1:LO_W]) * PH_W'(x_mag);
   end

   always_ff @(posedge clock) begin
      if (en.p) begin
         p_lo_ff <= p_lo_in;
         p_hi_ff <= p_hi_in;
         neg_ff  <= neg_in;
         c_ff    <= c;
      end
   end

   // recombine, round, cap, restore sign and add the coefficient
   always_comb begin
      cap    = |p_hi_ff[PH_W-1:CAP_B];
      lo_sum = {1'b0, p_lo_ff} + HALF;
      q_sum  = MAG_W'({p_hi_ff[CAP_B-1:0], {SH_P{1'b0}}}) + MAG_W'(lo_sum >> FRAC_BITS);
      q_cap  = (cap || (q_sum > CAP_VAL)) ? CAP_VAL : q_sum;
      prod   = neg_ff ? -acc_type'({1'b0, q_cap}) : acc_type'({1'b0, q_cap});
      y_in   = c_ff + prod;
   end

   always_ff @(posedge clock) begin
      if (en.s) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

[hdl/heat_index_polynomial_top.sv]
// heat index polynomial evaluator: fourteen-stage pipeline of Horner steps
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | req_temperature, req_humidity
//   rsp      | out       | rsp_valid/rsp_stall  | rsp_heat_index, rsp_saturated
//
// one sample enters every cycle while req_stall is low; its result passes the input register,
// six chained Horner steps of two stages each (multiply, then add) and the rounding/clamp
// output register before it is on the output
// synchronous active-high reset empties the pipeline; the data path is not cleared
// each stage holds while the next one is full and blocked, so bubbles are squeezed out
// and req_stall only rises once every stage holds a sample and rsp_stall is high
module heat_index_polynomial_top import hip_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [T_W-1:0]   req_temperature,
   input  logic        [RH_W-1:0]  req_humidity,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_heat_index,
   output logic                    rsp_saturated
);

   // stage map
   //   0        input register
   //   1..6     three humidity steps, all four rows side by side
   //   7..12    three temperature steps
   //   13       rounding to the output format and clamp
   localparam int NSTG = 14;
   localparam int LAST = NSTG - 1;

   logic [NSTG-1:0] v_ff, v_in;
   logic [NSTG-1:0] en;

   // sample carried along the stages that need it
   logic signed [T_W-1:0] t_ff  [0:10];
   logic [RH_W-1:0]       rh_ff [0:4];

   // row sums b1 and b0 wait for the temperature steps
   acc_type b1_ff [7:8];
   acc_type b0_ff [7:10];

   acc_type     row_y [4][3];
   acc_type     t_y   [3];
   step_en_type row_en [3];
   step_en_type t_en   [3];

   // ready chain: a stage loads when empty or when its content moves on
   always_comb begin
      en[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int s = LAST - 1; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
   end

   assign req_stall = !en[0];

   always_comb begin
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int s = 1; s < NSTG; s++) begin
         v_in[s] = en[s] ? v_ff[s-1] : v_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // sample carry registers
   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff[0]  <= req_temperature;
         rh_ff[0] <= req_humidity;
      end
      for (int s = 1; s <= 10; s++) begin
         if (en[s]) begin
            t_ff[s] <= t_ff[s-1];
         end
      end
      for (int s = 1; s <= 4; s++) begin
         if (en[s]) begin
            rh_ff[s] <= rh_ff[s-1];
         end
      end
   end

   // enables of all steps; humidity steps: row i starts from its cubic coefficient
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         row_en[k].p = en[1 + 2*k];
         row_en[k].s = en[2 + 2*k];
         t_en[k].p   = en[7 + 2*k];
         t_en[k].s   = en[8 + 2*k];
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_row
      for (genvar k = 0; k < 3; k++) begin : g_step
         acc_type               a_in;
         logic signed [X_W-1:0] rh_x;

         assign rh_x = $signed(X_W'(rh_ff[2*k]));

         if (k == 0) begin : g_first
            assign a_in = COEF[i][3];
         end else begin : g_next
            assign a_in = row_y[i][k-1];
         end

         hip_step u_step (
            .clock (clock),
            .en    (row_en[k]),
            .a     (a_in),
            .c     (COEF[i][2-k]),
            .x     (rh_x),
            .y     (row_y[i][k])
         );
      end
   end

   // row sums b1, b0 follow the temperature steps until they are needed
   always_ff @(posedge clock) begin
      if (en[7]) begin
         b1_ff[7] <= row_y[1][2];
         b0_ff[7] <= row_y[0][2];
      end
      if (en[8]) begin
         b1_ff[8] <= b1_ff[7];
         b0_ff[8] <= b0_ff[7];
      end
      for (int s = 9; s <= 10; s++) begin
         if (en[s]) begin
            b0_ff[s] <= b0_ff[s-1];
         end
      end
   end

   // temperature steps: acc = b3, then b2, b1, b0 folded in
   hip_step u_tstep0 (
      .clock (clock),
      .en    (t_en[0]),
      .a     (row_y[3][2]),
      .c     (row_y[2][2]),
      .x     (t_ff[6]),
      .y     (t_y[0])
   );

   hip_step u_tstep1 (
      .clock (clock),
      .en    (t_en[1]),
      .a     (t_y[0]),
      .c     (b1_ff[8]),
      .x     (t_ff[8]),
      .y     (t_y[1])
   );

   hip_step u_tstep2 (
      .clock (clock),
      .en    (t_en[2]),
      .a     (t_y[1]),
      .c     (b0_ff[10]),
      .x     (t_ff[10]),
      .y     (t_y[2])
   );

   // Q44 to output format, half away from zero, then clamp
   localparam logic [MAG_W-1:0] RND_HALF = MAG_W'(1) << (ROUND_SH - 1);

   logic [ACC_W-1:0]       acc_abs;
   logic [MAG_W-1:0]       acc_rnd;
   logic [RM_W-1:0]        acc_m;
   logic                   acc_neg;
   logic signed [OUT_W-1:0] heat_index_in, heat_index_ff;
   logic                   saturated_in, saturated_ff;

   always_comb begin
      acc_neg = t_y[2][ACC_W-1];
      acc_abs = acc_neg ? -t_y[2] : t_y[2];
      acc_rnd = acc_abs[MAG_W-1:0] + RND_HALF;
      acc_m   = acc_rnd[MAG_W-1:ROUND_SH];
      if (!acc_neg && (acc_m > RM_W'(OUT_MAX))) begin
         heat_index_in = OUT_W'(OUT_MAX);
         saturated_in  = 1'b1;
      end else if (acc_neg && (acc_m > RM_W'(OUT_MIN_M))) begin
         heat_index_in = OUT_W'(OUT_MIN_M);
         saturated_in  = 1'b1;
      end else begin
         heat_index_in = acc_neg ? -OUT_W'(acc_m) : OUT_W'(acc_m);
         saturated_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         heat_index_ff <= heat_index_in;
         saturated_ff  <= saturated_in;
      end
   end

   assign rsp_valid      = v_ff[LAST];
   assign rsp_heat_index = heat_index_ff;
   assign rsp_saturated  = saturated_ff;

   // input is only held off when every stage is occupied and the output is blocked
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&v_ff) && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // a sample leaving the last step always lands in the output register
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST-1] && en[LAST]) |=> rsp_valid)
      else $error("sample lost at the output register");

   // clamp flag only with a bound on the output
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         ((rsp_heat_index == OUT_W'(OUT_MAX)) || (rsp_heat_index == OUT_W'(OUT_MIN_M))))
      else $error("saturation flag without a clamped result");

   // reset empties every stage
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (v_ff == '0))
      else $error("pipeline not empty after reset");

endmodule
